@@ rtl/core/rrad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrad_pkg
// Shared widths, operation codes and condition codes of the RMS-reference
// apnea detector, plus the request/result structs of the square unit.
// ----------------------------------------------------------------------------
package rrad_pkg;

  localparam int OP_W     = 2;
  localparam int SAMPLE_W = 16;
  localparam int COND_W   = 2;
  localparam int SQ_W     = 31;   // (2^15)^2 needs 31 bits
  localparam int SUM_W    = 43;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [COND_W-1:0] COND_NORMAL = 2'd0;
  localparam logic [COND_W-1:0] COND_APNEA  = 2'd1;
  localparam logic [COND_W-1:0] COND_ERROR  = 2'd2;
  localparam logic [COND_W-1:0] COND_RESET  = 2'd3;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] value;
  } sq_req_t;

  typedef struct packed {
    logic            valid;
    logic            negative;
    logic [SQ_W-1:0] square;
  } sq_res_t;

endpackage

@@ rtl/core/rrad_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrad_req_if
// Request channel: operation code and sample, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrad_req_if;
  import rrad_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

@@ rtl/core/rrad_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrad_rsp_if
// Result channel: condition code and reference status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrad_rsp_if;
  import rrad_pkg::*;

  logic              valid;
  logic              ready;
  logic [COND_W-1:0] condition;
  logic              reference_ready;

  modport source (output valid, output condition, output reference_ready, input ready);
  modport sink   (input valid, input condition, input reference_ready, output ready);
endinterface

@@ rtl/core/rrad_square.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrad_square
// Shared squaring unit: registers |value|^2 and the sign of value, one
// request per cycle; the result is registered.
// ----------------------------------------------------------------------------
module rrad_square (
  input  logic             clk,
  input  logic             rst,
  input  rrad_pkg::sq_req_t req,
  output rrad_pkg::sq_res_t res
);
  import rrad_pkg::*;

  logic [SAMPLE_W-1:0]   mag;
  logic [2*SAMPLE_W-1:0] prod;

  // -32768 maps to 32768, which still fits the unsigned magnitude
  assign mag  = req.value[SAMPLE_W-1] ? (~req.value + SAMPLE_W'(1)) : req.value;
  assign prod = mag * mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= req.valid;
    end
    res.negative <= req.value[SAMPLE_W-1];
    res.square   <= prod[SQ_W-1:0];
  end

endmodule

@@ rtl/core/rms_reference_apnea_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_reference_apnea_detector_unit
// Sample ring with RMS reference; check scans the ring through one shared
// squaring unit and one constant-scaled compare against the sum of squares.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                            | Handshake
// req     | in  | operation[1:0], sample[15:0] s     | valid/ready
// rsp     | out | condition[1:0], reference_ready    | valid/ready
//
// After acceptance, a push waits in S_PUSH_WAIT for the square unit while
// the reference builds; other pushes, clear, unused code and check without
// a reference go to S_DONE. Check with a reference: S_SCAN over fill (written
// ring slots, at most RING_DEPTH), one memory read per cycle, then S_DRAIN.
// A result waits in the rsp register; the next request is taken meanwhile,
// but a finished step holds until rsp has room.
// Reset is synchronous; the ring needs no clearing pass, a fill count marks
// unwritten slots, which the check treats as zero.
// ----------------------------------------------------------------------------
module rms_reference_apnea_detector_unit #(
  parameter int RING_DEPTH  = 64,
  parameter int REF_SAMPLES = 256
) (
  input logic        clk,
  input logic        rst,
  rrad_req_if.sink   req,
  rrad_rsp_if.source rsp
);
  import rrad_pkg::*;

  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int CNT_W  = $clog2(REF_SAMPLES + 1);
  localparam logic [SUM_W-1:0]  REF_K    = SUM_W'(REF_SAMPLES);
  localparam logic [CNT_W-1:0]  REF_CNT  = CNT_W'(REF_SAMPLES);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(RING_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_WAIT,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state;

  logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata;
  logic                       rd_valid;

  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  idx;
  logic [FILL_W-1:0] fill;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              ref_valid;
  logic [COND_W-1:0] prev;
  logic [COND_W-1:0] cond;
  logic              hit;

  logic              out_valid;
  logic [COND_W-1:0] out_cond;
  logic              out_ref;

  logic    accept;
  logic    issue;
  logic    reach;
  sq_req_t sq_req;
  sq_res_t sq_res;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign issue     = (state == S_SCAN);

  assign rsp.valid           = out_valid;
  assign rsp.condition       = out_cond;
  assign rsp.reference_ready = out_ref;

  assign count_next = count + CNT_W'(1);

  // one squarer for both the running sum and the ring scan
  assign sq_req.valid = rd_valid ||
                        (accept && (req.operation == OP_PUSH) && !ref_valid);
  assign sq_req.value = rd_valid ? rdata : req.sample;

  rrad_square u_square (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .res (sq_res)
  );

  // sample reaches the reference when s >= 0 and s*s*REF_SAMPLES >= sum
  assign reach = !sq_res.negative && ((SUM_W'(sq_res.square) * REF_K) >= sum);

  always_ff @(posedge clk) begin
    if (accept && (req.operation == OP_PUSH)) begin
      ring[ptr] <= req.sample;
    end
    if (issue) begin
      rdata <= ring[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_valid  <= 1'b0;
      ptr       <= '0;
      idx       <= '0;
      fill      <= '0;
      sum       <= '0;
      count     <= '0;
      ref_valid <= 1'b0;
      prev      <= COND_NORMAL;
      hit       <= 1'b0;
      cond      <= COND_NORMAL;
    end else begin
      rd_valid <= issue;
      // S_DONE reloads the register itself
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (sq_res.valid && (state != S_PUSH_WAIT) && reach) begin
        hit <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            cond <= COND_NORMAL;
            case (req.operation)
              OP_PUSH: begin
                ptr <= (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
                if (fill != FILL_MAX) begin
                  fill <= fill + FILL_W'(1);
                end
                state <= ref_valid ? S_DONE : S_PUSH_WAIT;
              end
              OP_CHECK: begin
                if (!ref_valid) begin
                  prev  <= COND_NORMAL;
                  state <= S_DONE;
                end else begin
                  // an unwritten slot counts as zero: reaches only a zero sum
                  hit   <= (fill != FILL_MAX) && (sum == '0);
                  idx   <= '0;
                  state <= (fill == '0) ? S_DRAIN : S_SCAN;
                end
              end
              OP_CLEAR: begin
                ref_valid <= 1'b0;
                count     <= '0;
                sum       <= '0;
                state     <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_PUSH_WAIT: begin
          if (sq_res.valid) begin
            sum   <= sum + SUM_W'(sq_res.square);
            count <= count_next;
            if (count_next == REF_CNT) begin
              ref_valid <= 1'b1;
            end
            state <= S_DONE;
          end
        end

        S_SCAN: begin
          if (FILL_W'(idx) == (fill - FILL_W'(1))) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + PTR_W'(1);
          end
        end

        S_DRAIN: begin
          if (!rd_valid && !sq_res.valid) begin
            if (hit) begin
              cond <= (prev == COND_APNEA) ? COND_RESET : COND_NORMAL;
              prev <= (prev == COND_APNEA) ? COND_RESET : COND_NORMAL;
            end else begin
              cond <= (prev == COND_APNEA) ? COND_ERROR : COND_APNEA;
              prev <= (prev == COND_APNEA) ? COND_ERROR : COND_APNEA;
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_cond  <= cond;
            out_ref   <= ref_valid;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("ring fill count beyond depth");

  a_ref_count: assert property (@(posedge clk) disable iff (rst)
    ref_valid |-> (count == REF_CNT))
    else $error("reference valid with incomplete count");

  a_square_use: assert property (@(posedge clk) disable iff (rst)
    sq_res.valid |-> ((state == S_PUSH_WAIT) || (state == S_SCAN) || (state == S_DRAIN)))
    else $error("square result outside push or scan");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted transaction left no work in flight");

endmodule
